@@ src/gfla_pkg.sv @@
// ----------------------------------------------------------------------------
// gfla_pkg
// Shared types and constants of the grouped free list allocator.
// ----------------------------------------------------------------------------
package gfla_pkg;

	localparam int unsigned ENTRY_W        = 11;
	localparam int unsigned INDEX_W        = 10;
	localparam int unsigned COUNT_W        = 11;
	localparam int unsigned GROUP_SIZE_DEF = 16;
	localparam int unsigned NUM_BLOCKS     = 1024;
	localparam int unsigned ROW_W          = $clog2(NUM_BLOCKS);

	localparam logic [ENTRY_W-1:0] END_MARK  = {ENTRY_W{1'b1}};
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_LOOK,
		ST_SPILL,
		ST_RELOAD,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic rd;
		logic wr;
	} mem_ctl_t;

endpackage

@@ src/gfla_stack_ram.sv @@
// ----------------------------------------------------------------------------
// gfla_stack_ram
// In-core free stacks of both pools in one synchronous memory. Entry zero of
// a pool reads as the end sentinel until it is first written.
// ----------------------------------------------------------------------------
module gfla_stack_ram #(
	parameter int unsigned IDX_W = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  gfla_pkg::mem_ctl_t             ctl,
	input  logic                           pool,
	input  logic [IDX_W-1:0]               rd_idx,
	input  logic [IDX_W-1:0]               wr_idx,
	input  logic [gfla_pkg::ENTRY_W-1:0]   wr_data,
	output logic [gfla_pkg::ENTRY_W-1:0]   rd_data
);

	localparam int unsigned DEPTH = 2 << IDX_W;

	logic [gfla_pkg::ENTRY_W-1:0] mem [0:DEPTH-1];
	logic [gfla_pkg::ENTRY_W-1:0] rd_data_s1;
	logic                         sentinel_s1;
	logic [1:0]                   valid0_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[{pool, wr_idx}] <= wr_data;
		end
		if (ctl.rd) begin
			rd_data_s1  <= mem[{pool, rd_idx}];
			sentinel_s1 <= (rd_idx == '0) && !valid0_q[pool];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid0_q <= '0;
		end else if (ctl.wr && (wr_idx == '0)) begin
			valid0_q[pool] <= 1'b1;
		end
	end

	assign rd_data = sentinel_s1 ? gfla_pkg::END_MARK : rd_data_s1;

endmodule

@@ src/gfla_group_ram.sv @@
// ----------------------------------------------------------------------------
// gfla_group_ram
// Group store: spilled stack groups of both pools, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module gfla_group_ram #(
	parameter int unsigned ADDR_W = 15
) (
	input  logic                           clk,
	input  gfla_pkg::mem_ctl_t             ctl,
	input  logic [ADDR_W-1:0]              rd_addr,
	input  logic [ADDR_W-1:0]              wr_addr,
	input  logic [gfla_pkg::ENTRY_W-1:0]   wr_data,
	output logic [gfla_pkg::ENTRY_W-1:0]   rd_data
);

	logic [gfla_pkg::ENTRY_W-1:0] mem [0:(1 << ADDR_W)-1];

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ src/gfla_seq.sv @@
// ----------------------------------------------------------------------------
// gfla_seq
// Sequencer: per-pool depth and free counts, pop and push, and the spill and
// reload sweeps between the stack memory and the group store.
// ----------------------------------------------------------------------------
module gfla_seq #(
	parameter int unsigned GROUP_SIZE = gfla_pkg::GROUP_SIZE_DEF,
	parameter int unsigned IDX_W      = $clog2(GROUP_SIZE),
	parameter int unsigned GADDR_W    = 1 + gfla_pkg::ROW_W + IDX_W
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           in_op,
	input  logic                           in_pool,
	input  logic [gfla_pkg::INDEX_W-1:0]   in_blk,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [gfla_pkg::INDEX_W-1:0]   out_granted,
	output logic                           out_status,
	output logic [gfla_pkg::COUNT_W-1:0]   out_free,
	output gfla_pkg::mem_ctl_t             stk_ctl,
	output logic                           stk_pool,
	output logic [IDX_W-1:0]               stk_rd_idx,
	output logic [IDX_W-1:0]               stk_wr_idx,
	output logic [gfla_pkg::ENTRY_W-1:0]   stk_wr_data,
	input  logic [gfla_pkg::ENTRY_W-1:0]   stk_rd_data,
	output gfla_pkg::mem_ctl_t             grp_ctl,
	output logic [GADDR_W-1:0]             grp_rd_addr,
	output logic [GADDR_W-1:0]             grp_wr_addr,
	output logic [gfla_pkg::ENTRY_W-1:0]   grp_wr_data,
	input  logic [gfla_pkg::ENTRY_W-1:0]   grp_rd_data
);

	localparam int unsigned CNT_W = $clog2(GROUP_SIZE + 1);
	localparam logic [CNT_W-1:0] GS = CNT_W'(GROUP_SIZE);

	gfla_pkg::state_t state_q, state_d;

	logic                           op_q;
	logic                           pool_q;
	logic [gfla_pkg::INDEX_W-1:0]   blk_q;
	logic [gfla_pkg::ROW_W-1:0]     row_q;
	logic [CNT_W-1:0]               cnt_q;
	logic [gfla_pkg::INDEX_W-1:0]   granted_q;
	logic                           status_q;
	logic [CNT_W-1:0]               depth_q [2];
	logic [gfla_pkg::COUNT_W-1:0]   total_q [2];
	logic                           out_valid_q;
	logic [gfla_pkg::INDEX_W-1:0]   out_granted_q;
	logic                           out_status_q;
	logic [gfla_pkg::COUNT_W-1:0]   out_free_q;

	logic [CNT_W-1:0]               cur_depth;
	logic [gfla_pkg::COUNT_W-1:0]   cur_total;
	logic                           pool_empty;
	logic                           stack_full;
	logic                           link_end;
	logic                           load_out;
	logic [IDX_W-1:0]               cnt_idx;
	logic [IDX_W-1:0]               prev_idx;

	assign cur_depth  = depth_q[pool_q];
	assign cur_total  = total_q[pool_q];
	assign pool_empty = (cur_total == '0) || (cur_depth == '0);
	assign stack_full = (cur_depth >= GS);
	assign link_end   = (stk_rd_data == gfla_pkg::END_MARK);
	assign load_out   = !out_valid_q || out_ready;
	assign cnt_idx    = cnt_q[IDX_W-1:0];
	assign prev_idx   = IDX_W'(cnt_q - CNT_W'(1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gfla_pkg::ST_IDLE: begin
				if (in_valid) state_d = gfla_pkg::ST_DECIDE;
			end
			gfla_pkg::ST_DECIDE: begin
				if (op_q == gfla_pkg::OP_RELEASE) begin
					state_d = stack_full ? gfla_pkg::ST_SPILL : gfla_pkg::ST_FINISH;
				end else begin
					state_d = pool_empty ? gfla_pkg::ST_FINISH : gfla_pkg::ST_LOOK;
				end
			end
			gfla_pkg::ST_LOOK: begin
				if ((cur_depth == '0) && !link_end) state_d = gfla_pkg::ST_RELOAD;
				else state_d = gfla_pkg::ST_FINISH;
			end
			gfla_pkg::ST_SPILL,
			gfla_pkg::ST_RELOAD: begin
				if (cnt_q == GS) state_d = gfla_pkg::ST_FINISH;
			end
			gfla_pkg::ST_FINISH: begin
				if (load_out) state_d = gfla_pkg::ST_IDLE;
			end
			default: state_d = gfla_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		stk_ctl     = '0;
		stk_rd_idx  = '0;
		stk_wr_idx  = '0;
		stk_wr_data = {1'b0, blk_q};
		grp_ctl     = '0;
		grp_rd_addr = {pool_q, row_q, cnt_idx};
		grp_wr_addr = {pool_q, row_q, prev_idx};
		grp_wr_data = stk_rd_data;
		unique case (state_q)
			gfla_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			gfla_pkg::ST_DECIDE: begin
				if (op_q == gfla_pkg::OP_RELEASE) begin
					stk_ctl.wr = !stack_full;
					stk_wr_idx = cur_depth[IDX_W-1:0];
				end else begin
					stk_ctl.rd = !pool_empty;
					stk_rd_idx = IDX_W'(cur_depth - CNT_W'(1));
				end
			end
			gfla_pkg::ST_SPILL: begin
				stk_ctl.rd = (cnt_q != GS);
				stk_rd_idx = cnt_idx;
				grp_ctl.wr = (cnt_q != '0);
				stk_ctl.wr = (cnt_q == GS);
			end
			gfla_pkg::ST_RELOAD: begin
				grp_ctl.rd  = (cnt_q != GS);
				stk_ctl.wr  = (cnt_q != '0);
				stk_wr_idx  = prev_idx;
				stk_wr_data = grp_rd_data;
			end
			gfla_pkg::ST_LOOK,
			gfla_pkg::ST_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	assign stk_pool = pool_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gfla_pkg::ST_IDLE;
			depth_q[0]  <= CNT_W'(1);
			depth_q[1]  <= CNT_W'(1);
			total_q[0]  <= '0;
			total_q[1]  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				gfla_pkg::ST_DECIDE: begin
					if (op_q == gfla_pkg::OP_RELEASE) begin
						if (cur_total != gfla_pkg::COUNT_MAX) total_q[pool_q] <= cur_total + 1'b1;
						if (!stack_full) depth_q[pool_q] <= cur_depth + 1'b1;
					end else if (!pool_empty) begin
						total_q[pool_q] <= cur_total - 1'b1;
						depth_q[pool_q] <= cur_depth - 1'b1;
					end
				end
				gfla_pkg::ST_SPILL: begin
					if (cnt_q == GS) depth_q[pool_q] <= CNT_W'(1);
				end
				gfla_pkg::ST_RELOAD: begin
					if (cnt_q == GS) depth_q[pool_q] <= GS;
				end
				default: begin
				end
			endcase
			if ((state_q == gfla_pkg::ST_FINISH) && load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			gfla_pkg::ST_IDLE: begin
				if (in_valid) begin
					op_q   <= in_op;
					pool_q <= in_pool;
					blk_q  <= in_blk;
				end
			end
			gfla_pkg::ST_DECIDE: begin
				status_q  <= (op_q == gfla_pkg::OP_ALLOC) && pool_empty;
				granted_q <= '0;
				cnt_q     <= '0;
				row_q     <= gfla_pkg::ROW_W'(blk_q);
			end
			gfla_pkg::ST_LOOK: begin
				granted_q <= ((cur_depth == '0) && link_end) ? '0 :
					stk_rd_data[gfla_pkg::INDEX_W-1:0];
				row_q     <= stk_rd_data[gfla_pkg::ROW_W-1:0];
				cnt_q     <= '0;
			end
			gfla_pkg::ST_SPILL,
			gfla_pkg::ST_RELOAD: begin
				cnt_q <= cnt_q + 1'b1;
			end
			gfla_pkg::ST_FINISH: begin
				if (load_out) begin
					out_granted_q <= granted_q;
					out_status_q  <= status_q;
					out_free_q    <= cur_total;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign out_granted = out_granted_q;
	assign out_status  = out_status_q;
	assign out_free    = out_free_q;

endmodule

@@ src/grouped_free_list_allocator_core.sv @@
// ----------------------------------------------------------------------------
// grouped_free_list_allocator_core
// Two-pool grouped free list allocator (data blocks and inodes).
// ----------------------------------------------------------------------------
// One transfer in gives one transfer out. A release into a full stack spills
// GROUP_SIZE entries to the group store; an allocate that empties the stack
// reloads GROUP_SIZE entries. The spill and reload sweeps move one entry per
// cycle through the single write port of the destination memory. No clearing
// pass runs after reset; reloading a group that was never spilled returns
// undefined numbers. The next item is taken while a result waits at the
// output.
// ----------------------------------------------------------------------------
module grouped_free_list_allocator_core #(
	parameter int unsigned GROUP_SIZE = gfla_pkg::GROUP_SIZE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // block_index[9:0], zero fill
	input  logic [1:0]  s_tuser,   // operation[0], pool[1]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // granted_index[9:0], status[10], free_left[21:11]
);

	localparam int unsigned IDX_W   = $clog2(GROUP_SIZE);
	localparam int unsigned GADDR_W = 1 + gfla_pkg::ROW_W + IDX_W;

	gfla_pkg::mem_ctl_t             stk_ctl;
	logic                           stk_pool;
	logic [IDX_W-1:0]               stk_rd_idx;
	logic [IDX_W-1:0]               stk_wr_idx;
	logic [gfla_pkg::ENTRY_W-1:0]   stk_wr_data;
	logic [gfla_pkg::ENTRY_W-1:0]   stk_rd_data;
	gfla_pkg::mem_ctl_t             grp_ctl;
	logic [GADDR_W-1:0]             grp_rd_addr;
	logic [GADDR_W-1:0]             grp_wr_addr;
	logic [gfla_pkg::ENTRY_W-1:0]   grp_wr_data;
	logic [gfla_pkg::ENTRY_W-1:0]   grp_rd_data;
	logic [gfla_pkg::INDEX_W-1:0]   granted;
	logic                           status;
	logic [gfla_pkg::COUNT_W-1:0]   free_left;

	gfla_seq #(
		.GROUP_SIZE (GROUP_SIZE),
		.IDX_W      (IDX_W),
		.GADDR_W    (GADDR_W)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_op       (s_tuser[0]),
		.in_pool     (s_tuser[1]),
		.in_blk      (s_tdata[gfla_pkg::INDEX_W-1:0]),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_granted (granted),
		.out_status  (status),
		.out_free    (free_left),
		.stk_ctl     (stk_ctl),
		.stk_pool    (stk_pool),
		.stk_rd_idx  (stk_rd_idx),
		.stk_wr_idx  (stk_wr_idx),
		.stk_wr_data (stk_wr_data),
		.stk_rd_data (stk_rd_data),
		.grp_ctl     (grp_ctl),
		.grp_rd_addr (grp_rd_addr),
		.grp_wr_addr (grp_wr_addr),
		.grp_wr_data (grp_wr_data),
		.grp_rd_data (grp_rd_data)
	);

	gfla_stack_ram #(
		.IDX_W (IDX_W)
	) u_stack_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (stk_ctl),
		.pool    (stk_pool),
		.rd_idx  (stk_rd_idx),
		.wr_idx  (stk_wr_idx),
		.wr_data (stk_wr_data),
		.rd_data (stk_rd_data)
	);

	gfla_group_ram #(
		.ADDR_W (GADDR_W)
	) u_group_ram (
		.clk     (clk),
		.ctl     (grp_ctl),
		.rd_addr (grp_rd_addr),
		.wr_addr (grp_wr_addr),
		.wr_data (grp_wr_data),
		.rd_data (grp_rd_data)
	);

	assign m_tdata = {2'b00, free_left, status, granted};

endmodule

@@ tb/grouped_free_list_allocator_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grouped_free_list_allocator_core_tb
// Self-checking bench for the two-pool grouped free list allocator. A
// scoreboard tracks both in-core stacks, their free counts and the spilled
// groups, and predicts the grant of every request. Every result on the
// output stream is compared with its prediction. Stimulus: directed edge
// values, then random segments that grow and drain the stacks through
// spills and reloads. Both stream sides insert random gaps and stalls.
// ----------------------------------------------------------------------------
module grouped_free_list_allocator_core_tb;

	localparam int unsigned GROUP       = gfla_pkg::GROUP_SIZE_DEF;
	localparam int unsigned RANDOM_REQS = 1785;
	localparam int unsigned CYCLE_LIMIT = 800000;

	typedef struct {
		logic [gfla_pkg::INDEX_W-1:0] granted;
		logic                         status;
		logic [gfla_pkg::COUNT_W-1:0] left;
	} grant_result_t;

	class free_list_scoreboard;
		logic [gfla_pkg::ENTRY_W-1:0] stack_entries [2][GROUP];
		int unsigned                  depth [2];
		logic [gfla_pkg::COUNT_W-1:0] total [2];
		logic [gfla_pkg::ENTRY_W-1:0] group_rows [2][gfla_pkg::NUM_BLOCKS][GROUP];
		grant_result_t                pending_grants [$];
		int unsigned                  errors, requests, spills, reloads, exhaustions;

		function new();
			for (int p = 0; p < 2; p++) begin
				for (int i = 0; i < GROUP; i++)
					stack_entries[p][i] = '0;
				for (int r = 0; r < gfla_pkg::NUM_BLOCKS; r++)
					for (int i = 0; i < GROUP; i++)
						group_rows[p][r][i] = '0;
				stack_entries[p][0] = gfla_pkg::END_MARK;
				depth[p] = 1;
				total[p] = '0;
			end
		endfunction

		function int unsigned pending();
			return pending_grants.size();
		endfunction

		function void note_request(logic op, logic pool, logic [gfla_pkg::INDEX_W-1:0] idx);
			grant_result_t                r;
			int unsigned                  d;
			int unsigned                  row;
			logic [gfla_pkg::ENTRY_W-1:0] blk;
			r.granted = '0;
			r.status  = 1'b0;
			requests++;
			if (op == gfla_pkg::OP_ALLOC) begin
				d = depth[pool];
				if (total[pool] == 0 || d == 0 || d > GROUP) begin
					r.status = 1'b1;
					exhaustions++;
				end else begin
					d--;
					total[pool]--;
					depth[pool] = d;
					blk = stack_entries[pool][d];
					if (d == 0) begin
						if (blk == gfla_pkg::END_MARK) begin
							blk = '0;
						end else begin
							row = blk % gfla_pkg::NUM_BLOCKS;
							for (int i = 0; i < GROUP; i++)
								stack_entries[pool][i] = group_rows[pool][row][i];
							depth[pool] = GROUP;
							reloads++;
						end
					end
					r.granted = blk[gfla_pkg::INDEX_W-1:0];
				end
			end else begin
				if (total[pool] < gfla_pkg::COUNT_MAX)
					total[pool]++;
				if (depth[pool] < GROUP) begin
					stack_entries[pool][depth[pool]] = {1'b0, idx};
					depth[pool]++;
				end else begin
					row = idx % gfla_pkg::NUM_BLOCKS;
					for (int i = 0; i < GROUP; i++)
						group_rows[pool][row][i] = stack_entries[pool][i];
					depth[pool] = 1;
					stack_entries[pool][0] = {1'b0, idx};
					spills++;
				end
			end
			r.left = total[pool];
			pending_grants.push_back(r);
		endfunction

		function void check_grant(logic [23:0] d);
			grant_result_t e;
			if (pending_grants.size() == 0) begin
				$display("%0t: unexpected result granted=%0d status=%0d free_left=%0d",
					$time, d[9:0], d[10], d[21:11]);
				errors++;
			end else begin
				e = pending_grants.pop_front();
				if (d[9:0] !== e.granted || d[10] !== e.status || d[21:11] !== e.left) begin
					$display("%0t: mismatch expected granted=%0d status=%0d free_left=%0d",
						$time, e.granted, e.status, e.left);
					$display("%0t:          actual   granted=%0d status=%0d free_left=%0d",
						$time, d[9:0], d[10], d[21:11]);
					errors++;
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;

	int unsigned cycles = 0;

	free_list_scoreboard sb = new();

	grouped_free_list_allocator_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("grouped_free_list_allocator_core regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_grant(m_tdata);
			if (s_tvalid && s_tready)
				sb.note_request(s_tuser[0], s_tuser[1], s_tdata[gfla_pkg::INDEX_W-1:0]);
		end
	end

	initial begin
		int unsigned stall;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = $urandom_range(0, 13);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	task automatic send_request(input logic op, input logic pool,
		input logic [gfla_pkg::INDEX_W-1:0] idx);
		int unsigned gap;
		gap = $urandom_range(0, 13);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= {pool, op};
		s_tdata  <= {6'd0, idx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	initial begin
		int unsigned sent;
		int unsigned seg_len;
		int unsigned rel_pct;
		int unsigned pool_pct;
		logic        op;
		logic        pool;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty pools, extreme indexes, drain back to exhaustion
		send_request(gfla_pkg::OP_ALLOC, 1'b0, 10'd0);
		send_request(gfla_pkg::OP_ALLOC, 1'b1, 10'd0);
		send_request(gfla_pkg::OP_RELEASE, 1'b0, 10'd0);
		send_request(gfla_pkg::OP_RELEASE, 1'b0, 10'd1023);
		send_request(gfla_pkg::OP_RELEASE, 1'b0, 10'h2AA);
		send_request(gfla_pkg::OP_RELEASE, 1'b1, 10'h155);
		send_request(gfla_pkg::OP_RELEASE, 1'b1, 10'd1023);
		send_request(gfla_pkg::OP_ALLOC, 1'b0, 10'h3FF);
		send_request(gfla_pkg::OP_ALLOC, 1'b0, 10'd0);
		send_request(gfla_pkg::OP_ALLOC, 1'b0, 10'd0);
		send_request(gfla_pkg::OP_ALLOC, 1'b0, 10'd0);
		send_request(gfla_pkg::OP_ALLOC, 1'b1, 10'd0);
		send_request(gfla_pkg::OP_ALLOC, 1'b1, 10'd0);
		send_request(gfla_pkg::OP_ALLOC, 1'b1, 10'd0);
		send_request(gfla_pkg::OP_RELEASE, 1'b1, 10'd0);
		wait_drained();

		sent = 0;
		while (sent < RANDOM_REQS) begin
			seg_len  = $urandom_range(20, 120);
			pool_pct = $urandom_range(0, 100);
			case ($urandom_range(0, 2))
				0:       rel_pct = 25;
				1:       rel_pct = 50;
				default: rel_pct = 78;
			endcase
			for (int k = 0; k < seg_len && sent < RANDOM_REQS; k++) begin
				op   = ($urandom_range(0, 99) < rel_pct) ? gfla_pkg::OP_RELEASE :
					gfla_pkg::OP_ALLOC;
				pool = ($urandom_range(0, 99) < pool_pct);
				send_request(op, pool, 10'($urandom_range(0, 1023)));
				sent++;
			end
			if ($urandom_range(0, 5) == 0)
				wait_drained();
		end

		wait_drained();
		repeat (40) @(posedge clk);
		$display("covered %0d requests: %0d spills, %0d reloads, %0d exhausted allocates,",
			sb.requests, sb.spills, sb.reloads, sb.exhaustions);
		$display("random gaps and stalls on both sides, %0d mismatches", sb.errors);
		if (sb.errors == 0)
			$display("grouped_free_list_allocator_core regression: pass");
		else
			$display("grouped_free_list_allocator_core regression: fail");
		$finish;
	end

endmodule

@@ sim.f @@
src/gfla_pkg.sv
src/gfla_stack_ram.sv
src/gfla_group_ram.sv
src/gfla_seq.sv
src/grouped_free_list_allocator_core.sv
tb/grouped_free_list_allocator_core_tb.sv
